// ===== hdl/open_addressing_hash_table_unit_assert.svh =====
// Assertion macros for the hash table unit's RTL, used by oaht_ctrl.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef OPEN_ADDRESSING_HASH_TABLE_UNIT_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define OAHT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition in one cycle that requires another condition in the next cycle.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OAHT_ASSERT(label, prop, msg)
`define OAHT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== hdl/oaht_pkg.sv =====
// Package of the open-addressing hash table unit: sizes, codes and payload types.
// No dependencies; every other file of the unit but the assertion header uses it by scoped names.
package oaht_pkg;

  localparam int unsigned SLOTS      = 1024;
  localparam int unsigned FILL_LIMIT = 819;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IDX_W      = $clog2(SLOTS);
  localparam int unsigned CNT_W      = $clog2(SLOTS + 1);
  localparam int unsigned LIVE_W     = 11;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned MARK_W     = 2;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP  = 2'd0,
    OP_SET     = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_INVALID = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2
  } status_e;

  typedef enum logic [MARK_W-1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_TOMB  = 2'd2
  } mark_e;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    found_value;
    logic [LIVE_W-1:0]   live_count;
  } out_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    mark_e            wr_data;
  } mark_req_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } entry_req_t;

endpackage

// ===== hdl/oaht_mark_ram.sv =====
// Slot mark memory (empty, used, tombstone), one write and one read port.
// Read data is registered, available in the cycle after the request. Depends on oaht_pkg.
module oaht_mark_ram (
  input  logic                           clk_i,
  input  oaht_pkg::mark_req_t            req_i,
  output logic [oaht_pkg::MARK_W-1:0]    rdata_o
);

  logic [oaht_pkg::MARK_W-1:0] mem [oaht_pkg::SLOTS];
  logic [oaht_pkg::MARK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/oaht_entry_ram.sv =====
// Slot key and value memory, one write and one read port.
// Read data is registered, available in the cycle after the request. Depends on oaht_pkg.
module oaht_entry_ram (
  input  logic                 clk_i,
  input  oaht_pkg::entry_req_t req_i,
  output oaht_pkg::entry_t     rdata_o
);

  oaht_pkg::entry_t mem [oaht_pkg::SLOTS];
  oaht_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/oaht_ctrl.sv =====
// Sequencer of the hash table: clear sweep, probe walk, commit and result register.
// Depends on oaht_pkg and open_addressing_hash_table_unit_assert.svh.
`include "open_addressing_hash_table_unit_assert.svh"

module oaht_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  oaht_pkg::in_item_t             in_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output oaht_pkg::out_item_t            out_o,
  output oaht_pkg::mark_req_t            mark_req_o,
  input  logic [oaht_pkg::MARK_W-1:0]    mark_rdata_i,
  output oaht_pkg::entry_req_t           entry_req_o,
  input  oaht_pkg::entry_t               entry_rdata_i
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_PROBE  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [oaht_pkg::IDX_W-1:0] LAST_IDX = oaht_pkg::IDX_W'(oaht_pkg::SLOTS - 1);

  logic [1:0]                   state_q, state_d;
  logic [oaht_pkg::IDX_W-1:0]   clr_q, clr_d;
  logic [oaht_pkg::OP_W-1:0]    op_q, op_d;
  logic [oaht_pkg::KEY_W-1:0]   key_q, key_d;
  logic [oaht_pkg::VAL_W-1:0]   val_q, val_d;
  logic                         full_q, full_d;
  logic [oaht_pkg::IDX_W-1:0]   addr_q, addr_d;
  logic [oaht_pkg::IDX_W-1:0]   step_q, step_d;
  logic                         hit_q, hit_d;
  logic [oaht_pkg::IDX_W-1:0]   hit_at_q, hit_at_d;
  logic [oaht_pkg::VAL_W-1:0]   hit_val_q, hit_val_d;
  logic                         ins_q, ins_d;
  logic [oaht_pkg::IDX_W-1:0]   ins_at_q, ins_at_d;
  logic                         ins_tomb_q, ins_tomb_d;
  logic [oaht_pkg::CNT_W-1:0]   occ_q, occ_d;
  logic [oaht_pkg::CNT_W-1:0]   tomb_q, tomb_d;
  logic                         out_valid_q, out_valid_d;
  oaht_pkg::out_item_t          out_q, out_d;

  logic                         accept;
  logic                         finish;
  logic                         is_empty;
  logic                         is_tomb;
  logic                         is_hit;
  logic                         stop;
  logic [oaht_pkg::IDX_W-1:0]   next_addr;
  logic [oaht_pkg::CNT_W-1:0]   live;
  logic [oaht_pkg::CNT_W+oaht_pkg::LIVE_W-1:0] live_ext;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  // The result register can be loaded once the previous result has left or is leaving.
  assign finish     = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);

  assign is_empty  = (mark_rdata_i == oaht_pkg::MARK_EMPTY);
  assign is_tomb   = (mark_rdata_i == oaht_pkg::MARK_TOMB);
  assign is_hit    = (mark_rdata_i == oaht_pkg::MARK_USED) && (entry_rdata_i.key == key_q);
  assign stop      = is_empty || is_hit || (step_q == LAST_IDX);
  assign next_addr = addr_q + step_q + oaht_pkg::IDX_W'(1);

  assign live     = occ_d - tomb_d;
  assign live_ext = {{oaht_pkg::LIVE_W{1'b0}}, live};

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    val_d       = val_q;
    full_d      = full_q;
    addr_d      = addr_q;
    step_d      = step_q;
    hit_d       = hit_q;
    hit_at_d    = hit_at_q;
    hit_val_d   = hit_val_q;
    ins_d       = ins_q;
    ins_at_d    = ins_at_q;
    ins_tomb_d  = ins_tomb_q;
    occ_d       = occ_q;
    tomb_d      = tomb_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    mark_req_o          = '0;
    mark_req_o.wr_data  = oaht_pkg::MARK_EMPTY;
    entry_req_o         = '0;

    unique case (state_q)
      S_CLEAR: begin
        // One slot mark a cycle is reset to empty after reset.
        mark_req_o.we      = 1'b1;
        mark_req_o.wr_addr = clr_q;
        mark_req_o.wr_data = oaht_pkg::MARK_EMPTY;
        clr_d              = clr_q + oaht_pkg::IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          op_d       = in_i.operation;
          key_d      = in_i.key;
          val_d      = in_i.value;
          addr_d     = in_i.key[oaht_pkg::IDX_W-1:0];
          step_d     = '0;
          hit_d      = 1'b0;
          ins_d      = 1'b0;
          ins_tomb_d = 1'b0;
          full_d     = (in_i.operation == oaht_pkg::OP_SET) &&
                       (occ_q >= oaht_pkg::CNT_W'(oaht_pkg::FILL_LIMIT));
          mark_req_o.rd_en   = 1'b1;
          mark_req_o.rd_addr = in_i.key[oaht_pkg::IDX_W-1:0];
          entry_req_o.rd_en   = 1'b1;
          entry_req_o.rd_addr = in_i.key[oaht_pkg::IDX_W-1:0];
          if (full_d || (in_i.operation == oaht_pkg::OP_INVALID)) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // The slot at addr_q is evaluated while the next slot of the run is read.
        mark_req_o.rd_en    = 1'b1;
        mark_req_o.rd_addr  = next_addr;
        entry_req_o.rd_en   = 1'b1;
        entry_req_o.rd_addr = next_addr;
        if ((is_empty || is_tomb) && !ins_q) begin
          ins_d      = 1'b1;
          ins_at_d   = addr_q;
          ins_tomb_d = is_tomb;
        end
        if (is_hit) begin
          hit_d     = 1'b1;
          hit_at_d  = addr_q;
          hit_val_d = entry_rdata_i.value;
        end
        if (stop) begin
          state_d = S_FINISH;
        end else begin
          addr_d = next_addr;
          step_d = step_q + oaht_pkg::IDX_W'(1);
        end
      end
      S_FINISH: begin
        if (finish) begin
          out_d.status      = oaht_pkg::STAT_NOT_FOUND;
          out_d.found_value = '0;
          unique case (op_q)
            oaht_pkg::OP_LOOKUP: begin
              if (hit_q) begin
                out_d.status      = oaht_pkg::STAT_OK;
                out_d.found_value = hit_val_q;
              end
            end
            oaht_pkg::OP_SET: begin
              if (full_q) begin
                out_d.status = oaht_pkg::STAT_FULL;
              end else if (hit_q) begin
                entry_req_o.we      = 1'b1;
                entry_req_o.wr_addr = hit_at_q;
                entry_req_o.wr_data = '{key: key_q, value: val_q};
                out_d.status        = oaht_pkg::STAT_OK;
              end else if (ins_q) begin
                mark_req_o.we       = 1'b1;
                mark_req_o.wr_addr  = ins_at_q;
                mark_req_o.wr_data  = oaht_pkg::MARK_USED;
                entry_req_o.we      = 1'b1;
                entry_req_o.wr_addr = ins_at_q;
                entry_req_o.wr_data = '{key: key_q, value: val_q};
                if (ins_tomb_q) begin
                  if (tomb_q != '0) begin
                    tomb_d = tomb_q - oaht_pkg::CNT_W'(1);
                  end
                end else begin
                  occ_d = occ_q + oaht_pkg::CNT_W'(1);
                end
                out_d.status = oaht_pkg::STAT_OK;
              end else begin
                out_d.status = oaht_pkg::STAT_FULL;
              end
            end
            oaht_pkg::OP_REMOVE: begin
              if (hit_q) begin
                mark_req_o.we      = 1'b1;
                mark_req_o.wr_addr = hit_at_q;
                mark_req_o.wr_data = oaht_pkg::MARK_TOMB;
                tomb_d             = tomb_q + oaht_pkg::CNT_W'(1);
                out_d.status       = oaht_pkg::STAT_OK;
              end
            end
            default: begin
              out_d.status = oaht_pkg::STAT_NOT_FOUND;
            end
          endcase
          out_d.live_count = live_ext[oaht_pkg::LIVE_W-1:0];
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      occ_q       <= '0;
      tomb_q      <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      ins_q       <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      occ_q       <= occ_d;
      tomb_q      <= tomb_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      ins_q       <= ins_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    val_q      <= val_d;
    addr_q     <= addr_d;
    step_q     <= step_d;
    hit_at_q   <= hit_at_d;
    hit_val_q  <= hit_val_d;
    ins_at_q   <= ins_at_d;
    ins_tomb_q <= ins_tomb_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `OAHT_ASSERT(a_tomb_le_occ, tomb_q <= occ_q, "tombstone count exceeds occupied count")
  `OAHT_ASSERT(a_occ_limit, occ_q <= oaht_pkg::CNT_W'(oaht_pkg::FILL_LIMIT),
               "occupied count exceeds fill limit")
  `OAHT_ASSERT(a_no_write_in_probe,
               !(state_q == S_PROBE) || (!mark_req_o.we && !entry_req_o.we),
               "memory written during probe walk")
  `OAHT_ASSERT_NEXT(a_accept_moves, accept, (state_q == S_PROBE) || (state_q == S_FINISH),
                    "accepted transaction did not start processing")
  `OAHT_ASSERT_NEXT(a_finish_valid, finish, out_valid_q && (state_q == S_IDLE),
                    "finished transaction produced no result")

endmodule

// ===== hdl/open_addressing_hash_table_unit.sv =====
// Hash table unit with triangular probing and tombstones.
// The input channel (in_valid_i, in_ready_o, in_i) takes one transaction:
// operation lookup, set or remove, a 64-bit key and a 32-bit value.
// The output channel (out_valid_o, out_ready_i, out_o) returns one result per
// transaction: status, found value and the live entry count after it.
// Home slot is the key's low bits; probing steps by 1, 2, 3 and so on.
// A transaction is processed in order: the home slot is read on acceptance,
// then the slots of the run are probed (1 to 1024 of them), each evaluated
// while the next is read from the registered mark and entry memories, and
// the result is committed. A set refused at the fill limit or an unknown operation skips the probe walk.
// One transaction is processed at a time; the next is accepted as soon as the
// previous result is in the output register, even if it waits there.
// A stalled receiver holds the result register; processing then waits at
// commit until the register is free.
// After reset all 1024 slot marks are cleared, during which
// in_ready_o stays low.
// Depends on oaht_pkg, oaht_ctrl, oaht_mark_ram and oaht_entry_ram.
module open_addressing_hash_table_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  oaht_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output oaht_pkg::out_item_t out_o
);

  oaht_pkg::mark_req_t         mark_req;
  logic [oaht_pkg::MARK_W-1:0] mark_rdata;
  oaht_pkg::entry_req_t        entry_req;
  oaht_pkg::entry_t            entry_rdata;

  oaht_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_i          (in_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_o         (out_o),
    .mark_req_o    (mark_req),
    .mark_rdata_i  (mark_rdata),
    .entry_req_o   (entry_req),
    .entry_rdata_i (entry_rdata)
  );

  oaht_mark_ram u_mark_ram (
    .clk_i   (clk_i),
    .req_i   (mark_req),
    .rdata_o (mark_rdata)
  );

  oaht_entry_ram u_entry_ram (
    .clk_i   (clk_i),
    .req_i   (entry_req),
    .rdata_o (entry_rdata)
  );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for open_addressing_hash_table_unit (lookup, set, remove).
// A shadow table predicts each result; depends only on oaht_pkg and the unit's RTL.
module tb_top;

  typedef logic [oaht_pkg::IDX_W-1:0] slot_idx_t;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned FILL_BATCH  = 40;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  oaht_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  oaht_pkg::out_item_t out_data;

  // Shadow copy of the table contents and counters.
  oaht_pkg::mark_e            shadow_mark [oaht_pkg::SLOTS] =
                                '{default: oaht_pkg::MARK_EMPTY};
  logic [oaht_pkg::KEY_W-1:0] shadow_key  [oaht_pkg::SLOTS];
  logic [oaht_pkg::VAL_W-1:0] shadow_val  [oaht_pkg::SLOTS];
  int unsigned                shadow_occupied = 0;
  int unsigned                shadow_tombs = 0;

  oaht_pkg::in_item_t         ops_pending [$];
  oaht_pkg::out_item_t        results_due [$];
  logic [oaht_pkg::KEY_W-1:0] known_keys  [$];

  int unsigned tx_idle_pct = 16;
  int unsigned rx_idle_pct = 69;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  logic        in_taken = 1'b0;

  open_addressing_hash_table_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Walks the triangular probe sequence of a key through the shadow table.
  function automatic void probe_shadow(input logic [oaht_pkg::KEY_W-1:0] key,
                                       output bit hit, output slot_idx_t hit_at,
                                       output bit have_ins, output slot_idx_t ins_at);
    slot_idx_t b;
    hit = 1'b0;
    hit_at = '0;
    have_ins = 1'b0;
    ins_at = '0;
    b = key[oaht_pkg::IDX_W-1:0];
    for (int unsigned step = 0; step < oaht_pkg::SLOTS; step++) begin
      if (shadow_mark[b] == oaht_pkg::MARK_EMPTY) begin
        if (!have_ins) begin
          have_ins = 1'b1;
          ins_at = b;
        end
        return;
      end else if (shadow_mark[b] == oaht_pkg::MARK_TOMB) begin
        if (!have_ins) begin
          have_ins = 1'b1;
          ins_at = b;
        end
      end else if (shadow_key[b] == key) begin
        hit = 1'b1;
        hit_at = b;
        have_ins = 1'b0;
        return;
      end
      b = b + slot_idx_t'(step + 1);
    end
  endfunction

  // Applies one transaction to the shadow table and returns the result it must produce.
  function automatic oaht_pkg::out_item_t apply_to_shadow_table(
      input oaht_pkg::in_item_t item);
    oaht_pkg::out_item_t res;
    bit                  hit;
    bit                  have_ins;
    slot_idx_t           hit_at;
    slot_idx_t           ins_at;
    res.status = oaht_pkg::STAT_NOT_FOUND;
    res.found_value = '0;
    case (item.operation)
      oaht_pkg::OP_LOOKUP: begin
        probe_shadow(item.key, hit, hit_at, have_ins, ins_at);
        if (hit) begin
          res.status = oaht_pkg::STAT_OK;
          res.found_value = shadow_val[hit_at];
        end
      end
      oaht_pkg::OP_SET: begin
        // The fill check comes first, so even a replace is refused at the limit.
        if (shadow_occupied + 1 > oaht_pkg::FILL_LIMIT) begin
          res.status = oaht_pkg::STAT_FULL;
        end else begin
          probe_shadow(item.key, hit, hit_at, have_ins, ins_at);
          if (hit) begin
            shadow_val[hit_at] = item.value;
            res.status = oaht_pkg::STAT_OK;
          end else if (have_ins) begin
            if (shadow_mark[ins_at] == oaht_pkg::MARK_TOMB) begin
              if (shadow_tombs > 0) shadow_tombs--;
            end else begin
              shadow_occupied++;
            end
            shadow_mark[ins_at] = oaht_pkg::MARK_USED;
            shadow_key[ins_at] = item.key;
            shadow_val[ins_at] = item.value;
            res.status = oaht_pkg::STAT_OK;
          end else begin
            res.status = oaht_pkg::STAT_FULL;
          end
        end
      end
      oaht_pkg::OP_REMOVE: begin
        probe_shadow(item.key, hit, hit_at, have_ins, ins_at);
        if (hit) begin
          shadow_mark[hit_at] = oaht_pkg::MARK_TOMB;
          shadow_tombs++;
          res.status = oaht_pkg::STAT_OK;
        end
      end
      default: ;
    endcase
    res.live_count = oaht_pkg::LIVE_W'(shadow_occupied - shadow_tombs);
    return res;
  endfunction

  task automatic queue_op(input logic [oaht_pkg::OP_W-1:0] op,
                          input logic [oaht_pkg::KEY_W-1:0] key,
                          input logic [oaht_pkg::VAL_W-1:0] value);
    oaht_pkg::in_item_t item;
    item.operation = op;
    item.key = key;
    item.value = value;
    ops_pending.push_back(item);
    if (op == oaht_pkg::OP_SET) known_keys.push_back(key);
  endtask

  // Random transaction. Keys often repeat earlier ones or crowd a few home slots,
  // some of them next to the wrap point, so probe chains get long.
  task automatic queue_random(input bit fill_mode);
    logic [oaht_pkg::OP_W-1:0]  op;
    logic [oaht_pkg::KEY_W-1:0] key;
    logic [oaht_pkg::VAL_W-1:0] value;
    int unsigned                r;
    int unsigned                hot;
    r = $urandom_range(99);
    if (fill_mode) begin
      op = (r < 90) ? oaht_pkg::OP_SET : (r < 95) ? oaht_pkg::OP_LOOKUP : oaht_pkg::OP_REMOVE;
    end else begin
      op = (r < 25) ? oaht_pkg::OP_LOOKUP : (r < 70) ? oaht_pkg::OP_SET :
           (r < 95) ? oaht_pkg::OP_REMOVE : oaht_pkg::OP_INVALID;
    end
    key = {$urandom, $urandom};
    if (known_keys.size() > 0 && $urandom_range(99) < (fill_mode ? 5 : 55)) begin
      key = known_keys[$urandom_range(known_keys.size() - 1)];
    end else if ($urandom_range(99) < (fill_mode ? 10 : 35)) begin
      hot = $urandom_range(7);
      key[oaht_pkg::IDX_W-1:0] = (hot < 4) ? slot_idx_t'(hot) :
                                 slot_idx_t'(oaht_pkg::SLOTS - 8 + hot);
    end
    r = $urandom_range(9);
    value = (r == 0) ? '0 : (r == 1) ? '1 : $urandom;
    queue_op(op, key, value);
  endtask

  task automatic wait_idle();
    while (ops_pending.size() > 0 || in_valid || results_due.size() > 0) @(posedge clk_i);
  endtask

  task automatic report_mismatch(input string field,
                                 input logic [oaht_pkg::VAL_W-1:0] want,
                                 input logic [oaht_pkg::VAL_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    fail_count++;
  endtask

  // Driver: a new transaction is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid && !in_taken)) begin
      if (ops_pending.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_data <= ops_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_seen != rx_hold_req) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = LONG_HOLD;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: predicts on input transactions, checks output transactions.
  always @(posedge clk_i) begin : monitor
    oaht_pkg::out_item_t due;
    if (rst_ni) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) results_due.push_back(apply_to_shadow_table(in_data));
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          fail_count++;
        end else begin
          due = results_due.pop_front();
          if (out_data.status !== due.status)
            report_mismatch("status", oaht_pkg::VAL_W'(due.status),
                            oaht_pkg::VAL_W'(out_data.status));
          if (out_data.found_value !== due.found_value)
            report_mismatch("found_value", due.found_value, out_data.found_value);
          if (out_data.live_count !== due.live_count)
            report_mismatch("live_count", oaht_pkg::VAL_W'(due.live_count),
                            oaht_pkg::VAL_W'(out_data.live_count));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("%0t: timeout, no transaction for %0d cycles", $time, QUIET_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty table, unknown operation, collisions on home slot 0,
    // wrap from the last slot, replace, tombstones passed and reused.
    queue_op(oaht_pkg::OP_LOOKUP,  64'd0, 32'd0);
    queue_op(oaht_pkg::OP_REMOVE,  64'd0, 32'd0);
    queue_op(oaht_pkg::OP_INVALID, 64'd0, 32'd0);
    queue_op(oaht_pkg::OP_SET,     64'd0, 32'd0);
    queue_op(oaht_pkg::OP_SET,     '1, '1);
    queue_op(oaht_pkg::OP_LOOKUP,  '1, 32'd0);
    queue_op(oaht_pkg::OP_SET,     64'd1024, 32'h0000_00a5);
    queue_op(oaht_pkg::OP_SET,     64'd2048, 32'h1234_5678);
    queue_op(oaht_pkg::OP_SET,     64'h8000_0000_0000_0000, 32'h8000_0001);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd2048, '1);
    queue_op(oaht_pkg::OP_SET,     64'd0, 32'd1234);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd0, 32'd0);
    queue_op(oaht_pkg::OP_REMOVE,  64'd1024, 32'd0);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd2048, 32'd0);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd1024, 32'd0);
    queue_op(oaht_pkg::OP_SET,     64'd3072, 32'hdead_beef);
    queue_op(oaht_pkg::OP_REMOVE,  64'd1024, 32'd0);
    queue_op(oaht_pkg::OP_SET,     64'd2047, 32'h5555_aaaa);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd2047, 32'd0);
    queue_op(oaht_pkg::OP_REMOVE,  '1, 32'd0);
    queue_op(oaht_pkg::OP_LOOKUP,  64'd2047, 32'd0);
    queue_op(oaht_pkg::OP_INVALID, '1, '1);
    queue_op(oaht_pkg::OP_SET,     '1, 32'h0f0f_0f0f);
    queue_op(oaht_pkg::OP_LOOKUP,  64'h5555_5555_5555_5555, 32'haaaa_aaaa);
    queue_op(oaht_pkg::OP_LOOKUP,  64'h8000_0000_0000_0000, 32'd0);
    wait_idle();

    // Random with a slow receiver; the long hold-off lets the unit back up.
    repeat (120) queue_random(1'b0);
    rx_hold_req++;
    wait_idle();

    tx_idle_pct = 69;
    rx_idle_pct = 16;
    repeat (120) queue_random(1'b0);
    wait_idle();

    // No idling: fill the table to its limit, then keep working against it.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (shadow_occupied < oaht_pkg::FILL_LIMIT) begin
      repeat (FILL_BATCH) queue_random(1'b1);
      wait_idle();
    end
    repeat (60) queue_random(1'b0);
    wait_idle();

    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
